// ----- hdl/afd_pkg.sv -----
// ----------------------------------------------------------------------------
// afd_pkg: shared types and constants of the API frame deframer.
// Holds the frame constants, command and error codes, and the word formats
// passed between the front parser, the command queue and the back end.
// ----------------------------------------------------------------------------
package afd_pkg;

  // Frame delimiter and frame type codes.
  localparam logic [7:0] DELIM             = 8'h7E;
  localparam logic [7:0] TYPE_RX_PACKET    = 8'h90;
  localparam logic [7:0] TYPE_MODEM_STATUS = 8'h8A;
  localparam logic [7:0] TYPE_TX_STATUS    = 8'h8B;

  // Checksum target and highest good delivery status.
  localparam logic [7:0] SUM_OK         = 8'hFF;
  localparam logic [7:0] DELIVERY_LIMIT = 8'h75;

  // Minimum frame lengths of the known frame types.
  localparam logic [15:0] LEN_RX_MIN     = 16'd12;
  localparam logic [15:0] LEN_MODEM_MIN  = 16'd2;
  localparam logic [15:0] LEN_TX_MIN     = 16'd7;

  // Body index as carried in a command, saturated at IDX_MAX.
  localparam int          IDX_W            = 4;
  localparam logic [IDX_W-1:0] IDX_MAX     = 4'd15;
  localparam logic [IDX_W-1:0] IDX_TYPE    = 4'd0;
  localparam logic [IDX_W-1:0] IDX_PAYLOAD = 4'd12;

  // Command codes from the front parser to the back end.
  localparam logic [1:0] OP_BODY   = 2'd0;
  localparam logic [1:0] OP_CHECK  = 2'd1;
  localparam logic [1:0] OP_BADLEN = 2'd2;

  // Record kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Error codes of a summary record.
  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_CHECKSUM = 3'd1;
  localparam logic [2:0] ERR_ID       = 3'd2;
  localparam logic [2:0] ERR_DELIVERY = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd4;
  localparam logic [2:0] ERR_LENGTH   = 3'd5;

  // One classified byte.
  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic             short_rx;
    logic             short_modem;
    logic             short_tx;
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic        record_kind;
    logic [7:0]  type_code;
    logic [7:0]  payload_byte;
    logic [63:0] source_address;
    logic [15:0] network_address;
    logic [7:0]  rx_options;
    logic [7:0]  status_byte;
    logic [7:0]  retries;
    logic [7:0]  discovery;
    logic [7:0]  reported_id;
    logic [2:0]  error_code;
  } rec_t;

endpackage

// ----- hdl/api_frame_deframer_rx_core.sv -----
// ----------------------------------------------------------------------------
// api_frame_deframer_rx_core: receive deframer for 0x7E-delimited API frames.
// Input side: push rx_byte while full is low, one word per cycle at most.
// Output side: a word waits on the result ports while empty is low and is
// taken with pop. Receive-packet frames give one payload word per payload
// byte; every frame ends with one summary word carrying error_code.
// Configuration: cfg_wr_en writes cfg_wr_data as the expected frame id of
// transmit-status frames; write it only while the block is idle.
// Throughput is one byte per cycle while full is low. A byte that causes
// a word is written into the command queue at the edge that accepts it; the
// back end loads the word into its output register once that register frees.
// When the receiver stalls, the output register holds its word, the back end
// stops, the command queue fills and full rises after CMD_DEPTH more bytes
// that cause commands. Reset (rst, synchronous) empties the queue and the
// output, returns the parser to hunting for the delimiter and sets the
// expected frame id to 1.
// ----------------------------------------------------------------------------
module api_frame_deframer_rx_core #(
  parameter int MAX_LENGTH = 255,
  parameter int CMD_DEPTH  = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic        record_kind,
  output logic [7:0]  type_code,
  output logic [7:0]  payload_byte,
  output logic [63:0] source_address,
  output logic [15:0] network_address,
  output logic [7:0]  rx_options,
  output logic [7:0]  status_byte,
  output logic [7:0]  retries,
  output logic [7:0]  discovery,
  output logic [7:0]  reported_id,
  output logic [2:0]  error_code
);

  logic          in_take;
  logic          front_valid;
  afd_pkg::cmd_t front_cmd;
  afd_pkg::cmd_t queue_cmd;
  logic          queue_empty;
  logic          back_ready;
  logic          out_valid;
  afd_pkg::rec_t out_rec;

  assign in_take = push && !full;

  // Front parser.
  afd_front #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_take),
    .in_byte  (rx_byte),
    .cmd_valid(front_valid),
    .cmd      (front_cmd)
  );

  // Command queue.
  afd_cmd_fifo #(
    .DEPTH(CMD_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (front_valid),
    .wr_data(front_cmd),
    .rd_en  (back_ready),
    .rd_data(queue_cmd),
    .full   (full),
    .empty  (queue_empty)
  );

  // Back end.
  afd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd_valid  (!queue_empty),
    .cmd        (queue_cmd),
    .cmd_ready  (back_ready),
    .out_valid  (out_valid),
    .out_rec    (out_rec),
    .out_pop    (pop)
  );

  // Result ports.
  assign empty           = !out_valid;
  assign record_kind     = out_rec.record_kind;
  assign type_code       = out_rec.type_code;
  assign payload_byte    = out_rec.payload_byte;
  assign source_address  = out_rec.source_address;
  assign network_address = out_rec.network_address;
  assign rx_options      = out_rec.rx_options;
  assign status_byte     = out_rec.status_byte;
  assign retries         = out_rec.retries;
  assign discovery       = out_rec.discovery;
  assign reported_id     = out_rec.reported_id;
  assign error_code      = out_rec.error_code;

endmodule

// ----- hdl/afd_front.sv -----
// ----------------------------------------------------------------------------
// afd_front: frame parser front end.
// Hunts for the delimiter, reads the length, flags a bad length and classifies every body and
// checksum byte into a command for the back end.
// ----------------------------------------------------------------------------
module afd_front #(
  parameter int MAX_LENGTH = 255
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [7:0]     in_byte,
  output logic           cmd_valid,
  output afd_pkg::cmd_t  cmd
);

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_LEN_HI = 3'd1;
  localparam logic [2:0] PH_LEN_LO = 3'd2;
  localparam logic [2:0] PH_BODY   = 3'd3;
  localparam logic [2:0] PH_CHECK  = 3'd4;

  localparam logic [15:0] MAX_LEN = 16'(MAX_LENGTH);

  logic [2:0]  phase;
  logic [2:0]  phase_next;
  logic [7:0]  len_hi;
  logic [15:0] frame_length;
  logic [15:0] frame_length_next;
  logic [15:0] body_index;
  logic [15:0] body_index_next;
  logic [15:0] index_inc;
  logic [15:0] len_word;

  assign len_word  = {len_hi, in_byte};
  assign index_inc = body_index + 16'd1;

  // Phase sequencing and command generation for the word on the input.
  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    body_index_next   = body_index;
    cmd_valid         = 1'b0;
    cmd.op            = afd_pkg::OP_BODY;
    cmd.data          = in_byte;
    cmd.idx           = (body_index > 16'(afd_pkg::IDX_MAX)) ? afd_pkg::IDX_MAX
                                                             : body_index[afd_pkg::IDX_W-1:0];
    cmd.short_rx      = frame_length < afd_pkg::LEN_RX_MIN;
    cmd.short_modem   = frame_length < afd_pkg::LEN_MODEM_MIN;
    cmd.short_tx      = frame_length < afd_pkg::LEN_TX_MIN;
    if (in_valid) begin
      case (phase)
        PH_LEN_HI: begin
          phase_next = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_length_next = len_word;
          body_index_next   = 16'd0;
          if (len_word == 16'd0 || len_word > MAX_LEN) begin
            cmd_valid  = 1'b1;
            cmd.op     = afd_pkg::OP_BADLEN;
            phase_next = PH_HUNT;
          end else begin
            phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          cmd_valid       = 1'b1;
          cmd.op          = afd_pkg::OP_BODY;
          body_index_next = index_inc;
          if (index_inc >= frame_length) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          cmd_valid  = 1'b1;
          cmd.op     = afd_pkg::OP_CHECK;
          phase_next = PH_HUNT;
        end
        default: begin
          if (in_byte == afd_pkg::DELIM) begin
            phase_next = PH_LEN_HI;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      endcase
    end
  end

  // Phase, frame length and body index registers; reset clears them.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      frame_length <= 16'd0;
      body_index   <= 16'd0;
    end else begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      body_index   <= body_index_next;
    end
  end

  // High length byte is held until the low one arrives.
  always_ff @(posedge clk) begin
    if (in_valid && phase == PH_LEN_HI) begin
      len_hi <= in_byte;
    end
  end

endmodule

// ----- hdl/afd_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// afd_cmd_fifo: short command queue between the front and the back end.
// Register based, first in first out, with full and empty flags.
// ----------------------------------------------------------------------------
module afd_cmd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  afd_pkg::cmd_t  wr_data,
  input  logic           rd_en,
  output afd_pkg::cmd_t  rd_data,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  afd_pkg::cmd_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- hdl/afd_back.sv -----
// ----------------------------------------------------------------------------
// afd_back: frame back end.
// Executes commands from the queue: gathers the header fields of each frame,
// keeps the running sum and builds payload and summary words in the output
// register.
// ----------------------------------------------------------------------------
module afd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic [7:0]     cfg_wr_data,
  input  logic           cmd_valid,
  input  afd_pkg::cmd_t  cmd,
  output logic           cmd_ready,
  output logic           out_valid,
  output afd_pkg::rec_t  out_rec,
  input  logic           out_pop
);

  logic [7:0]  expected_id;
  logic [7:0]  cur_type;
  logic [7:0]  running_sum;
  logic [63:0] held_source;
  logic [15:0] held_network;
  logic [7:0]  held_options;
  logic [7:0]  held_status;
  logic [7:0]  held_retries;
  logic [7:0]  held_discovery;
  logic [7:0]  held_id;

  logic          take;
  logic [7:0]    sum_next;
  logic          is_rx;
  logic          is_modem;
  logic          is_tx;
  logic          too_short;
  logic [2:0]    frame_err;
  logic          emit;
  afd_pkg::rec_t rec_next;

  assign is_rx    = (cur_type == afd_pkg::TYPE_RX_PACKET);
  assign is_modem = (cur_type == afd_pkg::TYPE_MODEM_STATUS);
  assign is_tx    = (cur_type == afd_pkg::TYPE_TX_STATUS);
  assign sum_next = running_sum + cmd.data;

  // The output register frees when it is empty or is being taken.
  assign cmd_ready = !out_valid || out_pop;
  assign take      = cmd_valid && cmd_ready;

  // Frame error with checksum first, then length, type, id and delivery.
  assign too_short = (is_rx && cmd.short_rx) || (is_modem && cmd.short_modem) ||
                     (is_tx && cmd.short_tx);
  always_comb begin
    if (sum_next != afd_pkg::SUM_OK) begin
      frame_err = afd_pkg::ERR_CHECKSUM;
    end else if (too_short) begin
      frame_err = afd_pkg::ERR_LENGTH;
    end else if (!is_rx && !is_modem && !is_tx) begin
      frame_err = afd_pkg::ERR_UNKNOWN;
    end else if (is_tx && held_id != expected_id) begin
      frame_err = afd_pkg::ERR_ID;
    end else if (is_tx && held_status > afd_pkg::DELIVERY_LIMIT) begin
      frame_err = afd_pkg::ERR_DELIVERY;
    end else begin
      frame_err = afd_pkg::ERR_OK;
    end
  end

  // Build the outgoing word; fields not belonging to the frame type are zero.
  always_comb begin
    rec_next              = '0;
    emit                  = 1'b0;
    rec_next.type_code    = cur_type;
    if (is_rx) begin
      rec_next.source_address  = held_source;
      rec_next.network_address = held_network;
      rec_next.rx_options      = held_options;
    end else if (is_modem) begin
      rec_next.status_byte = held_status;
    end else if (is_tx) begin
      rec_next.network_address = held_network;
      rec_next.status_byte     = held_status;
      rec_next.retries         = held_retries;
      rec_next.discovery       = held_discovery;
      rec_next.reported_id     = held_id;
    end
    case (cmd.op)
      afd_pkg::OP_BODY: begin
        rec_next.record_kind  = afd_pkg::KIND_PAYLOAD;
        rec_next.payload_byte = cmd.data;
        emit = is_rx && (cmd.idx >= afd_pkg::IDX_PAYLOAD);
      end
      afd_pkg::OP_CHECK: begin
        rec_next.record_kind = afd_pkg::KIND_SUMMARY;
        rec_next.error_code  = frame_err;
        emit = 1'b1;
      end
      afd_pkg::OP_BADLEN: begin
        rec_next             = '0;
        rec_next.record_kind = afd_pkg::KIND_SUMMARY;
        rec_next.error_code  = afd_pkg::ERR_LENGTH;
        emit = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= 8'd1;
    end else if (cfg_wr_en) begin
      expected_id <= cfg_wr_data;
    end
  end

  // Output register: loads a new word or empties when the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_rec <= rec_next;
    end
  end

  // Frame type and running sum; the type byte opens a new frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_type    <= 8'd0;
      running_sum <= 8'd0;
    end else if (take && cmd.op == afd_pkg::OP_BODY) begin
      if (cmd.idx == afd_pkg::IDX_TYPE) begin
        cur_type    <= cmd.data;
        running_sum <= cmd.data;
      end else begin
        running_sum <= sum_next;
      end
    end
  end

  // Header field capture by frame type and byte position.
  always_ff @(posedge clk) begin
    if (take && cmd.op == afd_pkg::OP_BODY) begin
      if (cmd.idx == afd_pkg::IDX_TYPE) begin
        held_source    <= 64'd0;
        held_network   <= 16'd0;
        held_options   <= 8'd0;
        held_status    <= 8'd0;
        held_retries   <= 8'd0;
        held_discovery <= 8'd0;
        held_id        <= 8'd0;
      end else if (is_rx) begin
        if (cmd.idx <= 4'd8) begin
          held_source <= {held_source[55:0], cmd.data};
        end else if (cmd.idx <= 4'd10) begin
          held_network <= {held_network[7:0], cmd.data};
        end else if (cmd.idx == 4'd11) begin
          held_options <= cmd.data;
        end
      end else if (is_modem) begin
        if (cmd.idx == 4'd1) begin
          held_status <= cmd.data;
        end
      end else if (is_tx) begin
        case (cmd.idx)
          4'd1:       held_id        <= cmd.data;
          4'd2, 4'd3: held_network   <= {held_network[7:0], cmd.data};
          4'd4:       held_retries   <= cmd.data;
          4'd5:       held_status    <= cmd.data;
          4'd6:       held_discovery <= cmd.data;
          default:    held_id        <= held_id;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  // A waiting word that is not taken is still there on the next cycle.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_pop |=> out_valid)
    else $error("afd_back: waiting word lost");

  // Payload words come only from receive-packet frames.
  a_payload_type: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rec.record_kind == afd_pkg::KIND_PAYLOAD |->
      out_rec.type_code == afd_pkg::TYPE_RX_PACKET)
    else $error("afd_back: payload word outside a receive packet");

  // Payload words never carry an error.
  a_payload_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rec.record_kind == afd_pkg::KIND_PAYLOAD |->
      out_rec.error_code == afd_pkg::ERR_OK)
    else $error("afd_back: payload word with error code");

  // No command is taken while a waiting word blocks the output register.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_pop |-> !take)
    else $error("afd_back: command taken over a waiting word");
`endif

endmodule

// ----- dv/tb_api_frame_deframer_rx_core.sv -----
// ----------------------------------------------------------------------------
// tb_api_frame_deframer_rx_core: self-checking bench for the frame deframer.
// A short table of hand-picked bytes (noise, length errors, a delimiter inside
// a frame, a short frame, an unknown type, checksum priority) runs first.
// Random framed traffic of every frame type follows, under several expected
// frame id settings. Each accepted byte is run through a local model of the
// parser, and every word popped from the block is compared field by field.
// ----------------------------------------------------------------------------
module tb_api_frame_deframer_rx_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_LEN       = 255;
  localparam int          PAYLOAD_START = 12;
  localparam int          TOTAL_BYTES   = 1800;
  localparam int          PHASES        = 6;
  localparam int          SETTLE        = 8;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  // Parser phases of the local model.
  typedef enum logic [2:0] {PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_BODY, PH_CHECK} parse_phase_t;

  // One row of the directed table; chk marks a row whose summary is typed in.
  typedef struct packed {
    logic [7:0] data;
    logic       chk;
    logic       kind;
    logic [7:0] ftype;
    logic [2:0] err;
  } dir_row_t;

  localparam dir_row_t DIRECTED [29] = '{
    '{8'h00, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{8'hFF, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    // Zero length.
    '{afd_pkg::DELIM, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{8'h00, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{8'h00, 1'b1, afd_pkg::KIND_SUMMARY, 8'h00, afd_pkg::ERR_LENGTH},
    // Length one above the maximum.
    '{afd_pkg::DELIM, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{8'h01, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{8'h00, 1'b1, afd_pkg::KIND_SUMMARY, 8'h00, afd_pkg::ERR_LENGTH},
    // Modem status whose status byte is the delimiter.
    '{afd_pkg::DELIM, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{8'h00, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{8'h02, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{afd_pkg::TYPE_MODEM_STATUS, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{afd_pkg::DELIM, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{8'hF7, 1'b1, afd_pkg::KIND_SUMMARY, afd_pkg::TYPE_MODEM_STATUS, afd_pkg::ERR_OK},
    // Transmit status that is too short but has a good sum.
    '{afd_pkg::DELIM, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{8'h00, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{8'h01, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{afd_pkg::TYPE_TX_STATUS, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{8'h74, 1'b1, afd_pkg::KIND_SUMMARY, afd_pkg::TYPE_TX_STATUS, afd_pkg::ERR_LENGTH},
    // Unknown frame type.
    '{afd_pkg::DELIM, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{8'h00, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{8'h01, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{8'h55, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{8'hAA, 1'b1, afd_pkg::KIND_SUMMARY, 8'h55, afd_pkg::ERR_UNKNOWN},
    // Short frame with a bad sum: the checksum error wins.
    '{afd_pkg::DELIM, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{8'h00, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{8'h01, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{afd_pkg::TYPE_TX_STATUS, 1'b0, afd_pkg::KIND_PAYLOAD, 8'h00, afd_pkg::ERR_OK},
    '{8'h00, 1'b1, afd_pkg::KIND_SUMMARY, afd_pkg::TYPE_TX_STATUS, afd_pkg::ERR_CHECKSUM}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic        record_kind;
  logic [7:0]  type_code;
  logic [7:0]  payload_byte;
  logic [63:0] source_address;
  logic [15:0] network_address;
  logic [7:0]  rx_options;
  logic [7:0]  status_byte;
  logic [7:0]  retries;
  logic [7:0]  discovery;
  logic [7:0]  reported_id;
  logic [2:0]  error_code;

  // Typed-in expectation travelling with the byte on rx_byte.
  logic        tag_chk = 1'b0;
  logic        tag_kind = 1'b0;
  logic [7:0]  tag_type = 8'h00;
  logic [2:0]  tag_err = 3'd0;

  // Local model of the parser.
  parse_phase_t rx_phase;
  logic [15:0]  frm_len;
  logic [15:0]  body_idx;
  logic [7:0]   sum_acc;
  logic [7:0]   frm_type;
  logic [63:0]  src_addr;
  logic [15:0]  net_addr;
  logic [7:0]   opt_b, stat_b, retry_b, disc_b, rid_b;
  logic [7:0]   want_id;

  // Words predicted but not yet popped from the block.
  afd_pkg::rec_t pending_words[$];
  afd_pkg::rec_t made_word, out_word, due_word;
  bit            made;

  // Bookkeeping.
  int unsigned  cycles;
  int unsigned  bytes_sent;
  int unsigned  words_checked;
  int unsigned  payload_words;
  int unsigned  id_writes;
  int unsigned  mismatches;
  int unsigned  err_hist [8];
  logic [7:0]   cur_id = 8'd1;
  bit           tx_burst;
  bit           rd_burst;
  int unsigned  pop_hold;
  int unsigned  pop_draw;

  api_frame_deframer_rx_core #(
    .MAX_LENGTH(MAX_LEN)
  ) u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .push            (push),
    .full            (full),
    .rx_byte         (rx_byte),
    .empty           (empty),
    .pop             (pop),
    .record_kind     (record_kind),
    .type_code       (type_code),
    .payload_byte    (payload_byte),
    .source_address  (source_address),
    .network_address (network_address),
    .rx_options      (rx_options),
    .status_byte     (status_byte),
    .retries         (retries),
    .discovery       (discovery),
    .reported_id     (reported_id),
    .error_code      (error_code)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Prints one mismatch line, quietly after the first few dozen, and counts it.
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] exp);
    if (got !== exp)
      report_mismatch($sformatf("word %0d %s: got %0h, expected %0h",
                                words_checked, name, got, exp));
  endtask

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  // Forgets everything held for the current frame.
  function automatic void clear_frame();
    frm_len  = '0;
    body_idx = '0;
    sum_acc  = '0;
    frm_type = '0;
    src_addr = '0;
    net_addr = '0;
    opt_b    = '0;
    stat_b   = '0;
    retry_b  = '0;
    disc_b   = '0;
    rid_b    = '0;
  endfunction

  // Builds a word with the fields that belong to the current frame type.
  function automatic afd_pkg::rec_t frame_word(input logic kind, input logic [7:0] pay,
                                               input logic [2:0] err);
    afd_pkg::rec_t w;
    w = '0;
    w.record_kind  = kind;
    w.type_code    = frm_type;
    w.payload_byte = pay;
    w.error_code   = err;
    case (frm_type)
      afd_pkg::TYPE_RX_PACKET: begin
        w.source_address  = src_addr;
        w.network_address = net_addr;
        w.rx_options      = opt_b;
      end
      afd_pkg::TYPE_MODEM_STATUS: begin
        w.status_byte = stat_b;
      end
      afd_pkg::TYPE_TX_STATUS: begin
        w.network_address = net_addr;
        w.status_byte     = stat_b;
        w.retries         = retry_b;
        w.discovery       = disc_b;
        w.reported_id     = rid_b;
      end
      default: ;
    endcase
    return w;
  endfunction

  // Advances the model by one byte; returns 1 when the byte yields a word.
  function automatic bit deframe_byte(input logic [7:0] b, output afd_pkg::rec_t w);
    logic [15:0] idx;
    logic [2:0]  e;
    bit          got;
    got = 1'b0;
    w   = '0;
    case (rx_phase)
      PH_LEN_HI: begin
        frm_len  = {b, 8'h00};
        rx_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frm_len[7:0] = b;
        if (frm_len == 16'd0 || frm_len > MAX_LEN) begin
          frm_type = 8'h00;
          w        = frame_word(afd_pkg::KIND_SUMMARY, 8'h00, afd_pkg::ERR_LENGTH);
          got      = 1'b1;
          clear_frame();
          rx_phase = PH_HUNT;
        end else begin
          body_idx = '0;
          rx_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        idx     = body_idx;
        sum_acc = sum_acc + b;
        if (idx == 16'd0) begin
          frm_type = b;
        end else if (frm_type == afd_pkg::TYPE_RX_PACKET) begin
          if (idx <= 8) src_addr = {src_addr[55:0], b};
          else if (idx <= 10) net_addr = {net_addr[7:0], b};
          else if (idx == 11) opt_b = b;
        end else if (frm_type == afd_pkg::TYPE_MODEM_STATUS) begin
          if (idx == 1) stat_b = b;
        end else if (frm_type == afd_pkg::TYPE_TX_STATUS) begin
          if (idx == 1) rid_b = b;
          else if (idx <= 3) net_addr = {net_addr[7:0], b};
          else if (idx == 4) retry_b = b;
          else if (idx == 5) stat_b = b;
          else if (idx == 6) disc_b = b;
        end
        // Payload bytes of a receive packet come out one word each.
        if (frm_type == afd_pkg::TYPE_RX_PACKET && idx >= PAYLOAD_START) begin
          w   = frame_word(afd_pkg::KIND_PAYLOAD, b, afd_pkg::ERR_OK);
          got = 1'b1;
        end
        body_idx = idx + 16'd1;
        if (body_idx >= frm_len) rx_phase = PH_CHECK;
      end
      PH_CHECK: begin
        sum_acc = sum_acc + b;
        // Error priority: sum, length, type, frame id, delivery status.
        if (sum_acc != afd_pkg::SUM_OK)
          e = afd_pkg::ERR_CHECKSUM;
        else if ((frm_type == afd_pkg::TYPE_RX_PACKET &&
                  frm_len < afd_pkg::LEN_RX_MIN) ||
                 (frm_type == afd_pkg::TYPE_MODEM_STATUS &&
                  frm_len < afd_pkg::LEN_MODEM_MIN) ||
                 (frm_type == afd_pkg::TYPE_TX_STATUS &&
                  frm_len < afd_pkg::LEN_TX_MIN))
          e = afd_pkg::ERR_LENGTH;
        else if (frm_type != afd_pkg::TYPE_RX_PACKET &&
                 frm_type != afd_pkg::TYPE_MODEM_STATUS &&
                 frm_type != afd_pkg::TYPE_TX_STATUS)
          e = afd_pkg::ERR_UNKNOWN;
        else if (frm_type == afd_pkg::TYPE_TX_STATUS && rid_b != want_id)
          e = afd_pkg::ERR_ID;
        else if (frm_type == afd_pkg::TYPE_TX_STATUS && stat_b > afd_pkg::DELIVERY_LIMIT)
          e = afd_pkg::ERR_DELIVERY;
        else
          e = afd_pkg::ERR_OK;
        w   = frame_word(afd_pkg::KIND_SUMMARY, 8'h00, e);
        got = 1'b1;
        clear_frame();
        rx_phase = PH_HUNT;
      end
      default: begin
        if (b == afd_pkg::DELIM) begin
          clear_frame();
          rx_phase = PH_LEN_HI;
        end
      end
    endcase
    return got;
  endfunction

  // Model update on every accepted byte and check of every popped word.
  always @(posedge clk) begin
    if (rst) begin
      rx_phase = PH_HUNT;
      clear_frame();
      want_id = 8'd1;
    end else begin
      if (cfg_wr_en) want_id = cfg_wr_data;
      if (push && !full) begin
        made = deframe_byte(rx_byte, made_word);
        if (tag_chk && (!made || made_word.record_kind !== tag_kind ||
                        made_word.type_code !== tag_type ||
                        made_word.error_code !== tag_err))
          report_mismatch($sformatf("table row for byte %0h disagrees with prediction",
                                    rx_byte));
        if (made) pending_words.push_back(made_word);
      end
      if (pop && !empty) begin
        out_word = {record_kind, type_code, payload_byte, source_address, network_address,
                    rx_options, status_byte, retries, discovery, reported_id, error_code};
        if (pending_words.size() == 0) begin
          report_mismatch("word popped with nothing expected");
        end else begin
          due_word = pending_words.pop_front();
          check_field("record_kind", 64'(out_word.record_kind),
                      64'(due_word.record_kind));
          check_field("type_code", 64'(out_word.type_code), 64'(due_word.type_code));
          check_field("payload_byte", 64'(out_word.payload_byte),
                      64'(due_word.payload_byte));
          check_field("source_address", out_word.source_address, due_word.source_address);
          check_field("network_address", 64'(out_word.network_address),
                      64'(due_word.network_address));
          check_field("rx_options", 64'(out_word.rx_options), 64'(due_word.rx_options));
          check_field("status_byte", 64'(out_word.status_byte),
                      64'(due_word.status_byte));
          check_field("retries", 64'(out_word.retries), 64'(due_word.retries));
          check_field("discovery", 64'(out_word.discovery), 64'(due_word.discovery));
          check_field("reported_id", 64'(out_word.reported_id),
                      64'(due_word.reported_id));
          check_field("error_code", 64'(out_word.error_code), 64'(due_word.error_code));
        end
        words_checked++;
        if (record_kind == afd_pkg::KIND_PAYLOAD) payload_words++;
        else err_hist[error_code]++;
      end
    end
  end

  // Receiver: a random stall after each word, with stall-free stretches.
  always @(posedge clk) begin
    if (rst) begin
      pop      <= 1'b0;
      pop_hold <= 0;
    end else begin
      if ($urandom_range(0, 47) == 0) rd_burst <= ~rd_burst;
      if (pop && !empty) begin
        pop_draw = rd_burst ? 0 : $urandom_range(0, 7);
        pop_hold <= pop_draw;
        pop      <= (pop_draw == 0);
      end else if (pop_hold != 0) begin
        pop_hold <= pop_hold - 1;
        pop      <= (pop_hold == 1);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.", cycles,
               pending_words.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offers one byte after a random gap and returns at the edge that takes it.
  task automatic send_byte(input logic [7:0] b, input logic chk = 1'b0,
                           input logic kind = afd_pkg::KIND_PAYLOAD,
                           input logic [7:0] ftype = 8'h00,
                           input logic [2:0] err = afd_pkg::ERR_OK);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push     <= 1'b1;
    rx_byte  <= b;
    tag_chk  <= chk;
    tag_kind <= kind;
    tag_type <= ftype;
    tag_err  <= err;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  // Holds the sender until every predicted word has been popped, then lets the
  // block settle; bytes that make no word may still be in its pipeline.
  task automatic wait_idle();
    push <= 1'b0;
    do @(negedge clk); while (pending_words.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_frame_id(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    cur_id      = v;
    id_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Sends one random frame, sometimes with noise ahead, a bad sum or cut short.
  task automatic send_frame();
    logic [7:0]  body[$];
    logic [7:0]  t, csum;
    logic [15:0] len, min_len;
    int unsigned pick, n, keep;
    tx_burst = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) send_byte(($urandom_range(0, 7) == 0) ? afd_pkg::DELIM : rnd8());
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // Length field of zero or above the maximum.
      case ($urandom_range(0, 3))
        0:       len = 16'h0000;
        1:       len = 16'(MAX_LEN + 1);
        2:       len = 16'hFFFF;
        default: len = 16'($urandom_range(MAX_LEN + 1, 65535));
      endcase
      send_byte(afd_pkg::DELIM);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      return;
    end
    if (pick < 42) begin
      // Receive packet; now and then a long one, sometimes of maximum size.
      body.push_back(afd_pkg::TYPE_RX_PACKET);
      repeat (PAYLOAD_START - 1) body.push_back(rnd8());
      if ($urandom_range(0, 59) == 0)
        n = $urandom_range(0, 1) ? MAX_LEN - PAYLOAD_START
                                 : $urandom_range(40, MAX_LEN - PAYLOAD_START);
      else
        n = $urandom_range(0, 10);
      repeat (n) body.push_back(rnd8());
    end else if (pick < 62) begin
      // Transmit status, mostly with the expected frame id.
      body.push_back(afd_pkg::TYPE_TX_STATUS);
      body.push_back(($urandom_range(0, 2) != 0) ? cur_id : rnd8());
      repeat (3) body.push_back(rnd8());
      case ($urandom_range(0, 5))
        0:       body.push_back(afd_pkg::DELIVERY_LIMIT);
        1:       body.push_back(afd_pkg::DELIVERY_LIMIT + 8'd1);
        default: body.push_back(rnd8());
      endcase
      body.push_back(rnd8());
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) body.push_back(rnd8());
    end else if (pick < 76) begin
      // Modem status, sometimes with trailing bytes.
      body.push_back(afd_pkg::TYPE_MODEM_STATUS);
      body.push_back(rnd8());
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) body.push_back(rnd8());
    end else if (pick < 88) begin
      // Known type cut below its minimum length.
      case ($urandom_range(0, 2))
        0: begin
          t       = afd_pkg::TYPE_RX_PACKET;
          min_len = afd_pkg::LEN_RX_MIN;
        end
        1: begin
          t       = afd_pkg::TYPE_MODEM_STATUS;
          min_len = afd_pkg::LEN_MODEM_MIN;
        end
        default: begin
          t       = afd_pkg::TYPE_TX_STATUS;
          min_len = afd_pkg::LEN_TX_MIN;
        end
      endcase
      body.push_back(t);
      repeat ($urandom_range(0, min_len - 2)) body.push_back(rnd8());
    end else begin
      // Unknown frame type.
      do t = rnd8();
      while (t == afd_pkg::TYPE_RX_PACKET || t == afd_pkg::TYPE_MODEM_STATUS ||
             t == afd_pkg::TYPE_TX_STATUS);
      body.push_back(t);
      repeat ($urandom_range(0, 8)) body.push_back(rnd8());
    end
    len  = 16'(body.size());
    csum = afd_pkg::SUM_OK;
    foreach (body[i]) csum = csum - body[i];
    if ($urandom_range(0, 9) == 0) csum = csum ^ 8'($urandom_range(1, 255));
    keep = ($urandom_range(0, 24) == 0) ? $urandom_range(0, body.size()) : body.size() + 1;
    send_byte(afd_pkg::DELIM);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (int i = 0; i < body.size() && i < keep; i++) send_byte(body[i]);
    if (keep > body.size()) send_byte(csum);
  endtask

  // Main sequence.
  initial begin
    int unsigned phase_end;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table under the reset frame id.
    for (int i = 0; i < $size(DIRECTED); i++)
      send_byte(DIRECTED[i].data, DIRECTED[i].chk, DIRECTED[i].kind,
                DIRECTED[i].ftype, DIRECTED[i].err);

    // Random traffic, one frame id setting per phase, extremes first.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      // A stray delimiter may have left the parser inside a frame; pad it out.
      while (rx_phase != PH_HUNT) begin
        send_byte(8'h00);
        wait_idle();
      end
      if (p == 0) write_frame_id(8'hFF);
      else if (p == 1) write_frame_id(8'h01);
      else if (p == PHASES - 1) write_frame_id(8'hFF);
      else write_frame_id(8'($urandom_range(1, 255)));
      phase_end = (TOTAL_BYTES * (p + 1)) / PHASES;
      while (bytes_sent < phase_end) send_frame();
    end

    wait_idle();
    if (pending_words.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", pending_words.size()));
    $display("Run covered %0d bytes under %0d frame id settings; %0d words checked, %0d payload.",
             bytes_sent, id_writes + 1, words_checked, payload_words);
    $display("Summaries by error: ok %0d, sum %0d, id %0d, delivery %0d, type %0d, length %0d.",
             err_hist[afd_pkg::ERR_OK], err_hist[afd_pkg::ERR_CHECKSUM],
             err_hist[afd_pkg::ERR_ID], err_hist[afd_pkg::ERR_DELIVERY],
             err_hist[afd_pkg::ERR_UNKNOWN], err_hist[afd_pkg::ERR_LENGTH]);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
